// File: sv/short_term_plasticity_synapse_assert.svh
// ----------------------------------------------------------------------------
// short-term plasticity synapse assertion macros
// Clocked on clk, quiet while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SHORT_TERM_PLASTICITY_SYNAPSE_ASSERT_SVH
`define SHORT_TERM_PLASTICITY_SYNAPSE_ASSERT_SVH

// condition now implies consequence in the same cycle
`define STPS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// condition now implies consequence in the next cycle
`define STPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/stps_pkg.sv
// ----------------------------------------------------------------------------
// stps_pkg
// Shared widths, register codes, control structs and the 2^-f table.
// ----------------------------------------------------------------------------
package stps_pkg;

  localparam int FRAC_BITS       = 16;
  localparam int EXP_TABLE_DEPTH = 64;
  localparam int Q_W             = FRAC_BITS;
  localparam int IDX_W           = $clog2(EXP_TABLE_DEPTH);
  localparam int TIME_W          = 32;
  localparam int REG_W           = 16;
  localparam int COND_W          = 32;
  localparam int CFG_IDX_W       = 3;

  localparam logic [Q_W-1:0] UNITY = '1;
  localparam logic [Q_W-1:0] HALF  = Q_W'(1) << (FRAC_BITS - 1);

  localparam logic [32:0] LOG2E_Q32 = 33'd6196328019;
  localparam logic [47:0] EXP_LIMIT = 48'(64) << 16;
  localparam logic [7:0]  K_LIMIT   = 8'd40;

  localparam logic [Q_W-1:0] FACIL_RESET = Q_W'(({16'd13107, {Q_W{1'b0}}}) >> 16);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_USE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RECOV_RATE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FACIL_RATE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IS_EXC     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_EXC_SCALE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_INH_SCALE  = 3'd5;

  typedef struct packed {
    logic load;
    logic rate_u;
    logic rec_x;
    logic rec_u;
    logic strength;
    logic update;
    logic finish;
  } stps_cmd_t;

  typedef struct packed {
    logic seen;
  } stps_stat_t;

  typedef logic [32:0] exp_tab_t [EXP_TABLE_DEPTH];

  function automatic logic [32:0] q32_mul(input logic [32:0] a, input logic [32:0] b);
    logic [65:0] p;
    p = 66'(a) * 66'(b) + (66'd1 << 31);
    return p[64:32];
  endfunction

  // root of one half by bisection, then its powers
  function automatic exp_tab_t build_exp_tab();
    exp_tab_t    tab;
    logic [32:0] lo;
    logic [32:0] hi;
    logic [32:0] mid;
    logic [32:0] p;
    lo = 33'd1 << 31;
    hi = 33'h0_FFFF_FFFF;
    while (lo < hi) begin
      mid = lo + ((hi - lo + 33'd1) >> 1);
      p = 33'd1 << 32;
      for (int i = 0; i < EXP_TABLE_DEPTH; i++) begin
        p = q32_mul(p, mid);
      end
      if (p <= (33'd1 << 31)) begin
        lo = mid;
      end else begin
        hi = mid - 33'd1;
      end
    end
    p = 33'd1 << 32;
    for (int i = 0; i < EXP_TABLE_DEPTH; i++) begin
      tab[i] = p;
      p = q32_mul(p, lo);
    end
    return tab;
  endfunction

  localparam exp_tab_t EXP_TAB = build_exp_tab();

  // q0.16 register value to internal fraction
  function automatic logic [Q_W-1:0] to_frac(input logic [REG_W-1:0] v);
    logic [Q_W+REG_W-1:0] w;
    w = {v, {Q_W{1'b0}}} >> 16;
    return w[Q_W-1:0];
  endfunction

  // internal fraction to q0.16, rounded and saturated
  function automatic logic [REG_W-1:0] to_q16(input logic [Q_W-1:0] v);
    logic [Q_W+16:0] w;
    w = ({1'b0, v, 16'd0} + (Q_W+17)'(HALF)) >> FRAC_BITS;
    return (w > (Q_W+17)'(16'hFFFF)) ? 16'hFFFF : w[REG_W-1:0];
  endfunction

endpackage

// File: sv/stps_if.sv
// ----------------------------------------------------------------------------
// stps channel interfaces
// Valid/ready channels for spike beats and result beats.
// ----------------------------------------------------------------------------
interface stps_in_if import stps_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [TIME_W-1:0] spike_time;
  logic [REG_W-1:0]  syn_weight;

  modport source (output valid, spike_time, syn_weight, input ready);
  modport sink   (input valid, spike_time, syn_weight, output ready);
endinterface

interface stps_out_if import stps_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [COND_W-1:0] conductance;
  logic [REG_W-1:0]  strength;

  modport source (output valid, conductance, strength, input ready);
  modport sink   (input valid, conductance, strength, output ready);
endinterface

// File: sv/stps_ctrl.sv
// ----------------------------------------------------------------------------
// stps_ctrl
// Sequencer for one spike: decay pipeline, recovery, strength, update, output.
// ----------------------------------------------------------------------------
module stps_ctrl import stps_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       out_ready,
  output logic       out_valid,
  input  stps_stat_t stat,
  output stps_cmd_t  cmd
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_E1X  = 4'd1;
  localparam logic [3:0] ST_E1U  = 4'd2;
  localparam logic [3:0] ST_E3X  = 4'd3;
  localparam logic [3:0] ST_RX   = 4'd4;
  localparam logic [3:0] ST_RU   = 4'd5;
  localparam logic [3:0] ST_STR  = 4'd6;
  localparam logic [3:0] ST_UPD  = 4'd7;
  localparam logic [3:0] ST_OUT  = 4'd8;

  logic [3:0] state_r;
  logic [3:0] state_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;
  logic       out_free;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = stat.seen ? ST_E1X : ST_STR;
        end
      end
      ST_E1X: state_nxt = ST_E1U;
      ST_E1U: state_nxt = ST_E3X;
      ST_E3X: state_nxt = ST_RX;
      ST_RX:  state_nxt = ST_RU;
      ST_RU:  state_nxt = ST_STR;
      ST_STR: state_nxt = ST_UPD;
      ST_UPD: state_nxt = ST_OUT;
      ST_OUT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.load     = (state_r == ST_IDLE) && in_valid;
    cmd.rate_u   = (state_r == ST_E1U);
    cmd.rec_x    = (state_r == ST_RX);
    cmd.rec_u    = (state_r == ST_RU);
    cmd.strength = (state_r == ST_STR);
    cmd.update   = (state_r == ST_UPD);
    cmd.finish   = (state_r == ST_OUT) && out_free;
  end

  assign out_valid_nxt = cmd.finish || (out_valid_r && !out_ready);
  assign in_ready      = (state_r == ST_IDLE);
  assign out_valid     = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// File: sv/stps_datapath.sv
// ----------------------------------------------------------------------------
// stps_datapath
// Config registers, synapse state, exp decay pipeline and q0.16 arithmetic.
// ----------------------------------------------------------------------------
module stps_datapath import stps_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [REG_W-1:0]     cfg_data,
  input  logic [TIME_W-1:0]    in_spike_time,
  input  logic [REG_W-1:0]     in_syn_weight,
  input  stps_cmd_t            cmd,
  output stps_stat_t           stat,
  output logic [COND_W-1:0]    out_conductance,
  output logic [REG_W-1:0]     out_strength
);

  // rounded fraction product, saturated to unity
  function automatic logic [Q_W-1:0] qmul(input logic [Q_W-1:0] a, input logic [Q_W-1:0] b);
    logic [2*Q_W:0] p;
    p = ((2*Q_W+1)'(a) * (2*Q_W+1)'(b) + (2*Q_W+1)'(HALF)) >> FRAC_BITS;
    return (p > (2*Q_W+1)'(UNITY)) ? UNITY : p[Q_W-1:0];
  endfunction

  logic [REG_W-1:0]  base_use_r;
  logic [REG_W-1:0]  recov_rate_r;
  logic [REG_W-1:0]  facil_rate_r;
  logic              is_exc_r;
  logic [REG_W-1:0]  exc_scale_r;
  logic [REG_W-1:0]  inh_scale_r;

  logic [Q_W-1:0]    x_r;
  logic [Q_W-1:0]    x_nxt;
  logic [Q_W-1:0]    u_r;
  logic [Q_W-1:0]    u_nxt;
  logic [TIME_W-1:0] last_r;
  logic              seen_r;

  logic [REG_W-1:0]  w_r;
  logic [TIME_W-1:0] interval_r;
  logic [47:0]       a_r;
  logic              zero_r;
  logic [5:0]        k_r;
  logic [IDX_W-1:0]  idx_r;
  logic [Q_W-1:0]    fac_r;
  logic [Q_W-1:0]    s_r;
  logic [REG_W-1:0]  s16_r;
  logic [31:0]       gw_r;
  logic [COND_W-1:0] cond_r;
  logic [REG_W-1:0]  str_r;

  logic [Q_W-1:0]    ub;
  logic [REG_W-1:0]  rate_sel;
  logic [55:0]       b_prod;
  logic [23:0]       b_val;
  logic [15:0]       f_val;
  logic [16+IDX_W-1:0] f_scaled;
  logic              zero_nxt;
  logic [32:0]       tab_v;
  logic [33:0]       fac_rnd;
  logic [Q_W-1:0]    fac_nxt;
  logic [Q_W:0]      u_sum;
  logic [REG_W-1:0]  s16_nxt;
  logic [REG_W-1:0]  scale;
  logic [48:0]       g_full;
  logic [32:0]       g_shift;

  assign ub       = to_frac(base_use_r);
  assign rate_sel = cmd.rate_u ? facil_rate_r : recov_rate_r;
  assign scale    = is_exc_r ? exc_scale_r : inh_scale_r;

  // decay stage two: log2 e scaling, split into shift and table index
  assign b_prod   = 56'(a_r[22:0]) * 56'(LOG2E_Q32) + (56'd1 << 31);
  assign b_val    = b_prod[55:32];
  assign f_val    = b_val[15:0];
  assign f_scaled = (16+IDX_W)'(f_val) * (16+IDX_W)'(EXP_TABLE_DEPTH);
  assign zero_nxt = (a_r > EXP_LIMIT) || (b_val[23:16] >= K_LIMIT);

  // decay stage three: table, shift, round
  assign tab_v   = EXP_TAB[idx_r] >> k_r;
  assign fac_rnd = (34'(tab_v) + (34'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);
  always_comb begin
    if (zero_r) begin
      fac_nxt = '0;
    end else if (fac_rnd > 34'(UNITY)) begin
      fac_nxt = UNITY;
    end else begin
      fac_nxt = fac_rnd[Q_W-1:0];
    end
  end

  always_comb begin
    x_nxt = x_r;
    u_nxt = u_r;
    u_sum = {1'b0, u_r};
    if (cmd.rec_x) begin
      x_nxt = UNITY - qmul(UNITY - x_r, fac_r);
    end
    if (cmd.rec_u) begin
      if (u_r >= ub) begin
        u_sum = {1'b0, ub} + {1'b0, qmul(u_r - ub, fac_r)};
      end else begin
        u_sum = {1'b0, ub} - {1'b0, qmul(ub - u_r, fac_r)};
      end
      u_nxt = (u_sum > {1'b0, UNITY}) ? UNITY : u_sum[Q_W-1:0];
    end
    if (cmd.update) begin
      u_sum = {1'b0, u_r} + {1'b0, qmul(ub, UNITY - u_r)};
      u_nxt = (u_sum > {1'b0, UNITY}) ? UNITY : u_sum[Q_W-1:0];
      x_nxt = (s_r > x_r) ? '0 : x_r - s_r;
    end
  end

  assign s16_nxt = to_q16(s_r);
  assign g_full  = 49'(gw_r) * 49'(scale) + (49'd1 << 15);
  assign g_shift = g_full[48:16];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_use_r   <= 16'd13107;
      recov_rate_r <= 16'd164;
      facil_rate_r <= 16'd655;
      is_exc_r     <= 1'b1;
      exc_scale_r  <= 16'd256;
      inh_scale_r  <= 16'd256;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_BASE_USE:   base_use_r   <= cfg_data;
        CFG_RECOV_RATE: recov_rate_r <= cfg_data;
        CFG_FACIL_RATE: facil_rate_r <= cfg_data;
        CFG_IS_EXC:     is_exc_r     <= cfg_data[0];
        CFG_EXC_SCALE:  exc_scale_r  <= cfg_data;
        CFG_INH_SCALE:  inh_scale_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r    <= UNITY;
      u_r    <= FACIL_RESET;
      last_r <= '0;
      seen_r <= 1'b0;
    end else begin
      x_r <= x_nxt;
      u_r <= u_nxt;
      if (cmd.load) begin
        last_r <= in_spike_time;
        seen_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    a_r    <= 48'(interval_r) * 48'(rate_sel);
    zero_r <= zero_nxt;
    k_r    <= b_val[21:16];
    idx_r  <= f_scaled[16+IDX_W-1:16];
    fac_r  <= fac_nxt;
    if (cmd.load) begin
      w_r        <= in_syn_weight;
      interval_r <= (in_spike_time >= last_r) ? in_spike_time - last_r : '0;
    end
    if (cmd.strength) begin
      s_r <= qmul(u_r, x_r);
    end
    if (cmd.update) begin
      s16_r <= s16_nxt;
      gw_r  <= 32'(w_r) * 32'(s16_nxt);
    end
    if (cmd.finish) begin
      cond_r <= g_shift[32] ? '1 : g_shift[31:0];
      str_r  <= s16_r;
    end
  end

  assign stat.seen       = seen_r;
  assign out_conductance = cond_r;
  assign out_strength    = str_r;

endmodule

// File: sv/short_term_plasticity_synapse.sv
// ----------------------------------------------------------------------------
// short_term_plasticity_synapse
// Depressing/facilitating synapse: one spike beat in, one result beat out.
//
// in_bus carries spike_time and syn_weight; out_bus returns conductance
// (q16.16, saturating) and strength (q0.16). Registers are written through
// cfg_we/cfg_idx/cfg_data while no spike is in flight; the user must keep
// to this, as the block itself does not enforce it. A spike that follows
// an earlier one runs through both decay factors in a three-stage exp
// pipeline (interval times rate, log2 e scaling, table and shift), then
// recovery, strength, update and conductance; in_ready returns together
// with out_valid, one spike being worked on at a time. The first spike
// after reset skips the decay. The result sits in an output register; if
// the receiver stalls, the next spike may be taken and worked on, and only
// its final step waits for the register to drain. Reset restores the
// configuration registers, full resources, the baseline facilitation and
// the no-spike-yet state.
// ----------------------------------------------------------------------------
`include "short_term_plasticity_synapse_assert.svh"

module short_term_plasticity_synapse import stps_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  stps_in_if.sink              in_bus,
  stps_out_if.source           out_bus,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [REG_W-1:0]     cfg_data
);

  stps_cmd_t  cmd;
  stps_stat_t stat;
  logic       in_ready;
  logic       out_valid;

  stps_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_bus.valid),
    .in_ready  (in_ready),
    .out_ready (out_bus.ready),
    .out_valid (out_valid),
    .stat      (stat),
    .cmd       (cmd)
  );

  stps_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_idx         (cfg_idx),
    .cfg_data        (cfg_data),
    .in_spike_time   (in_bus.spike_time),
    .in_syn_weight   (in_bus.syn_weight),
    .cmd             (cmd),
    .stat            (stat),
    .out_conductance (out_bus.conductance),
    .out_strength    (out_bus.strength)
  );

  assign in_bus.ready  = in_ready;
  assign out_bus.valid = out_valid;

  `STPS_ASSERT_NEXT(a_one_spike, in_bus.valid && in_ready, !in_ready, "second spike taken in flight")
  `STPS_ASSERT_NEXT(a_seen_after_beat, in_bus.valid && in_ready, stat.seen, "spike not recorded")
  `STPS_ASSERT_NEXT(a_finish_shows, cmd.finish, out_valid, "result not presented")
  `STPS_ASSERT_SAME(a_no_overwrite, cmd.finish, !out_valid || out_bus.ready, "pending result lost")

endmodule

// File: dv/tb_short_term_plasticity_synapse.sv
// ----------------------------------------------------------------------------
// tb_short_term_plasticity_synapse
// Self-checking bench for the short-term plasticity synapse. A queue-fed
// driver offers spike beats. An independent fixed-point predictor of the
// resource and facilitation dynamics works out conductance and strength for
// each accepted spike. A monitor compares every result beat with the oldest
// prediction. Phases change the register settings and the idle patterns on
// both channels. One phase holds the receiver off long enough to back up
// the block.
// ----------------------------------------------------------------------------
module tb_short_term_plasticity_synapse import stps_pkg::*; ();

  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_HI = 3'd7;

  localparam logic [15:0] Q_ONE        = 16'hFFFF;
  localparam logic [15:0] USE_AT_RESET = 16'd13107;
  localparam logic [63:0] LOG2E_FIX    = 64'd6196328019;
  localparam int          QUIET_LIMIT  = 2000;
  localparam int          HOLD_CYCLES  = 300;
  localparam int          MAX_REPORTS  = 200;

  typedef struct packed {
    logic [TIME_W-1:0] stamp;
    logic [REG_W-1:0]  weight;
  } spike_beat_t;

  typedef struct packed {
    logic [COND_W-1:0] conductance;
    logic [REG_W-1:0]  strength;
  } synapse_result_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [REG_W-1:0]     cfg_data;

  stps_in_if  in_if ();
  stps_out_if out_if ();

  short_term_plasticity_synapse i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_bus   (in_if),
    .out_bus  (out_if),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  // predictor settings and state
  logic [15:0]       use_base;
  logic [15:0]       recov_rate;
  logic [15:0]       facil_rate;
  logic              exc_sel;
  logic [15:0]       exc_gain;
  logic [15:0]       inh_gain;
  logic [15:0]       rsrc_x;
  logic [15:0]       facil_level;
  logic [TIME_W-1:0] prev_stamp;
  logic              had_spike;
  logic [63:0]       pow2_frac [EXP_TABLE_DEPTH];

  spike_beat_t     spike_backlog [$];
  synapse_result_t expected_responses [$];

  int                queued_spikes;
  int                accepted_spikes;
  int                mismatches;
  int                gap_pct;
  int                stall_pct;
  int                quiet_cycles;
  bit                squeeze_go;
  logic              rx_hold;
  logic [TIME_W-1:0] spike_clock;

  always #2 clk = ~clk;

  function automatic logic [63:0] mul_q32(input logic [63:0] a, input logic [63:0] b);
    return (a * b + 64'h8000_0000) >> 32;
  endfunction

  function automatic logic [15:0] qmul(input logic [15:0] a, input logic [15:0] b);
    logic [32:0] p;
    p = (33'(a) * 33'(b) + 33'h8000) >> 16;
    return (p > 33'hFFFF) ? Q_ONE : p[15:0];
  endfunction

  // exp(-gap * rate) through 2^-(a log2 e), table plus shift
  function automatic logic [15:0] decay_to(input logic [TIME_W-1:0] gap,
                                           input logic [15:0] rate);
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] k;
    logic [63:0] idx;
    logic [63:0] v;
    logic [63:0] r;
    a = 64'(gap) * 64'(rate);
    if (a > (64'd64 << 16)) return '0;
    b = (a * LOG2E_FIX + 64'h8000_0000) >> 32;
    k = b >> 16;
    idx = ((b & 64'hFFFF) * 64'(EXP_TABLE_DEPTH)) >> 16;
    if (idx >= 64'(EXP_TABLE_DEPTH)) idx = 64'(EXP_TABLE_DEPTH - 1);
    if (k >= 64'd40) return '0;
    v = pow2_frac[idx] >> k;
    r = (v + 64'h8000) >> 16;
    return (r > 64'hFFFF) ? Q_ONE : r[15:0];
  endfunction

  function automatic synapse_result_t synapse_response(input logic [TIME_W-1:0] stamp,
                                                       input logic [REG_W-1:0] weight);
    synapse_result_t   res;
    logic [TIME_W-1:0] gap;
    logic [15:0]       ex;
    logic [15:0]       eu;
    logic [15:0]       s;
    logic [15:0]       gain;
    logic [16:0]       acc;
    logic [63:0]       g;
    if (had_spike) begin
      gap = (stamp >= prev_stamp) ? stamp - prev_stamp : '0;
      ex = decay_to(gap, recov_rate);
      eu = decay_to(gap, facil_rate);
      rsrc_x = Q_ONE - qmul(Q_ONE - rsrc_x, ex);
      if (facil_level >= use_base) begin
        acc = 17'(use_base) + 17'(qmul(facil_level - use_base, eu));
      end else begin
        acc = 17'(use_base) - 17'(qmul(use_base - facil_level, eu));
      end
      facil_level = (acc > 17'hFFFF) ? Q_ONE : acc[15:0];
    end
    s = qmul(facil_level, rsrc_x);
    acc = 17'(facil_level) + 17'(qmul(use_base, Q_ONE - facil_level));
    facil_level = (acc > 17'hFFFF) ? Q_ONE : acc[15:0];
    rsrc_x = (s > rsrc_x) ? '0 : rsrc_x - s;
    prev_stamp = stamp;
    had_spike = 1'b1;
    gain = exc_sel ? exc_gain : inh_gain;
    g = (64'(weight) * 64'(s) * 64'(gain) + 64'h8000) >> 16;
    res.conductance = (g > 64'hFFFF_FFFF) ? '1 : g[COND_W-1:0];
    res.strength = s;
    return res;
  endfunction

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] data);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we   <= 1'b0;
    case (idx)
      CFG_BASE_USE:   use_base = data;
      CFG_RECOV_RATE: recov_rate = data;
      CFG_FACIL_RATE: facil_rate = data;
      CFG_IS_EXC:     exc_sel = data[0];
      CFG_EXC_SCALE:  exc_gain = data;
      CFG_INH_SCALE:  inh_gain = data;
      default: ;
    endcase
  endtask

  function automatic logic [REG_W-1:0] pick_reg_value();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2, 3, 4: return REG_W'($urandom_range(1, 2000));
      default: return REG_W'($urandom);
    endcase
  endfunction

  task automatic pick_settings();
    cfg_write(CFG_BASE_USE, pick_reg_value());
    cfg_write(CFG_RECOV_RATE, pick_reg_value());
    cfg_write(CFG_FACIL_RATE, pick_reg_value());
    cfg_write(CFG_IS_EXC, REG_W'($urandom));
    cfg_write(CFG_EXC_SCALE, pick_reg_value());
    cfg_write(CFG_INH_SCALE, pick_reg_value());
    if ($urandom_range(0, 1) == 0) cfg_write(CFG_UNMAPPED_HI, REG_W'($urandom));
  endtask

  task automatic queue_spike(input logic [TIME_W-1:0] stamp, input logic [REG_W-1:0] weight);
    spike_beat_t b;
    b.stamp = stamp;
    b.weight = weight;
    spike_backlog.push_back(b);
    queued_spikes++;
    spike_clock = stamp;
  endtask

  task automatic queue_random_spikes(input int n);
    logic [TIME_W-1:0] stamp;
    logic [REG_W-1:0]  weight;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 19))
        0:          stamp = spike_clock;
        1:          stamp = TIME_W'($urandom);
        2:          stamp = spike_clock - TIME_W'($urandom_range(1, 1000));
        3, 4:       stamp = spike_clock + TIME_W'($urandom_range(2001, 1 << 20));
        5, 6, 7, 8, 9, 10, 11:
                    stamp = spike_clock + TIME_W'($urandom_range(1, 20));
        default:    stamp = spike_clock + TIME_W'($urandom_range(21, 2000));
      endcase
      case ($urandom_range(0, 9))
        0:       weight = '0;
        1:       weight = '1;
        default: weight = REG_W'($urandom);
      endcase
      queue_spike(stamp, weight);
    end
  endtask

  // wait until every queued spike is in and every result is out
  task automatic settle();
    while (!(accepted_spikes == queued_spikes && expected_responses.size() == 0))
      @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  // spike driver
  always @(posedge clk) begin
    spike_beat_t     nxt;
    synapse_result_t resp;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        resp = synapse_response(in_if.spike_time, in_if.syn_weight);
        expected_responses.push_back(resp);
        accepted_spikes++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (spike_backlog.size() != 0 && $urandom_range(0, 99) >= gap_pct) begin
          nxt = spike_backlog.pop_front();
          in_if.valid      <= 1'b1;
          in_if.spike_time <= nxt.stamp;
          in_if.syn_weight <= nxt.weight;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    synapse_result_t want;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (expected_responses.size() == 0) begin
          if (mismatches < MAX_REPORTS)
            $display("%0t: unexpected result beat, expected none, got cond %h str %h",
                     $time, out_if.conductance, out_if.strength);
          mismatches++;
        end else begin
          want = expected_responses.pop_front();
          if (out_if.conductance !== want.conductance) begin
            if (mismatches < MAX_REPORTS)
              $display("%0t: conductance mismatch, expected %h, got %h",
                       $time, want.conductance, out_if.conductance);
            mismatches++;
          end
          if (out_if.strength !== want.strength) begin
            if (mismatches < MAX_REPORTS)
              $display("%0t: strength mismatch, expected %h, got %h",
                       $time, want.strength, out_if.strength);
            mismatches++;
          end
        end
      end
      out_if.ready <= !rx_hold && ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // long receiver hold-off so the block backs up
  initial begin
    rx_hold = 1'b0;
    wait (squeeze_go);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    logic [63:0] p;
    int          gaps [4];
    int          stalls [4];

    clk              = 1'b0;
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_idx          = '0;
    cfg_data         = '0;
    in_if.valid      = 1'b0;
    in_if.spike_time = '0;
    in_if.syn_weight = '0;
    out_if.ready     = 1'b0;
    queued_spikes    = 0;
    accepted_spikes  = 0;
    mismatches       = 0;
    quiet_cycles     = 0;
    gap_pct          = 0;
    stall_pct        = 0;
    squeeze_go       = 1'b0;
    spike_clock      = '0;

    // 2^(-i/depth) in q32.32 from the depth-th root of one half
    lo = 64'd1 << 31;
    hi = (64'd1 << 32) - 1;
    while (lo < hi) begin
      mid = lo + (hi - lo + 1) / 2;
      p = 64'd1 << 32;
      for (int i = 0; i < EXP_TABLE_DEPTH; i++) p = mul_q32(p, mid);
      if (p <= (64'd1 << 31)) lo = mid;
      else hi = mid - 1;
    end
    p = 64'd1 << 32;
    for (int i = 0; i < EXP_TABLE_DEPTH; i++) begin
      pow2_frac[i] = p;
      p = mul_q32(p, lo);
    end

    use_base    = USE_AT_RESET;
    recov_rate  = 16'd164;
    facil_rate  = 16'd655;
    exc_sel     = 1'b1;
    exc_gain    = 16'd256;
    inh_gain    = 16'd256;
    rsrc_x      = Q_ONE;
    facil_level = USE_AT_RESET;
    prev_stamp  = '0;
    had_spike   = 1'b0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: first spike, zero interval, weight extremes, backward time
    queue_spike(32'd0, 16'h0000);
    queue_spike(32'd0, 16'hFFFF);
    queue_spike(32'd1, 16'h0100);
    queue_spike(32'd3, 16'h0100);
    queue_spike(32'd10, 16'h8000);
    queue_spike(32'd100, 16'h7FFF);
    queue_spike(32'd100000, 16'h0100);
    queue_spike(32'd5, 16'h00FF);
    queue_spike(32'hFFFF_FFFF, 16'hFFFF);
    queue_spike(32'hFFFF_FFFE, 16'h5555);
    settle();

    // top settings, inhibitory selected, unmapped indexes written
    cfg_write(CFG_BASE_USE, 16'hFFFF);
    cfg_write(CFG_RECOV_RATE, 16'hFFFF);
    cfg_write(CFG_FACIL_RATE, 16'hFFFF);
    cfg_write(CFG_IS_EXC, 16'hFFFE);
    cfg_write(CFG_EXC_SCALE, 16'h0000);
    cfg_write(CFG_INH_SCALE, 16'hFFFF);
    cfg_write(CFG_UNMAPPED_LO, 16'h1234);
    cfg_write(CFG_UNMAPPED_HI, 16'hFFFF);
    queue_spike(32'hFFFF_FFFF, 16'hFFFF);
    queue_spike(32'hFFFF_FFFF, 16'hFFFF);
    queue_spike(32'd0, 16'h0001);
    queue_spike(32'd2, 16'h8000);
    queue_spike(32'd2, 16'hFFFF);
    queue_spike(32'd200, 16'hFFFF);
    settle();

    // bottom settings, excitatory at full scale
    cfg_write(CFG_BASE_USE, 16'h0000);
    cfg_write(CFG_RECOV_RATE, 16'h0000);
    cfg_write(CFG_FACIL_RATE, 16'h0000);
    cfg_write(CFG_IS_EXC, 16'hAAAB);
    cfg_write(CFG_EXC_SCALE, 16'hFFFF);
    queue_spike(32'd300, 16'hFFFF);
    queue_spike(32'd301, 16'hFFFF);
    queue_spike(32'd100000, 16'hAAAA);
    queue_spike(32'd100000, 16'h0000);
    queue_spike(32'd4000000000, 16'h1234);
    settle();

    gaps   = '{0, 66, 0, 21};
    stalls = '{0, 0, 66, 21};
    for (int ph = 0; ph < 4; ph++) begin
      pick_settings();
      gap_pct   = gaps[ph];
      stall_pct = stalls[ph];
      queue_random_spikes(180);
      settle();
    end

    // receiver held off while spikes keep coming
    pick_settings();
    gap_pct    = 0;
    stall_pct  = 0;
    squeeze_go = 1'b1;
    queue_random_spikes(40);
    settle();

    pick_settings();
    gap_pct   = 21;
    stall_pct = 21;
    queue_random_spikes(40);
    settle();

    repeat (12) @(posedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+sv
sv/stps_pkg.sv
sv/stps_if.sv
sv/stps_ctrl.sv
sv/stps_datapath.sv
sv/short_term_plasticity_synapse.sv
dv/tb_short_term_plasticity_synapse.sv
